// File: rtl/line_sensor_ring_direction_defines.svh
// assertion macros for the line sensor ring direction rtl
`ifndef LINE_SENSOR_RING_DIRECTION_DEFINES_SVH
`define LINE_SENSOR_RING_DIRECTION_DEFINES_SVH

// same-cycle implication, checked on clk, disabled in reset
`define LSRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, disabled in reset
`define LSRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lsrd_pkg.sv
// package with types, constants and tables of the line sensor ring direction block
package lsrd_pkg;

  localparam int INNER_SENSORS_DEF = 24;
  localparam int FRAME_BYTES_DEF   = 6;
  localparam int NUM_SENSORS       = 30;
  localparam int BYTE_W            = 8;
  localparam int BITS_PER_BYTE     = 5;
  localparam logic [BYTE_W-1:0] START_CODE = 8'h1F;
  localparam logic [NUM_SENSORS-1:0] MASK_RESET = 30'h0802001;

  localparam int SUM_W    = 20;
  localparam int XY_W     = 32;
  localparam int Z_W      = 24;
  localparam int SQ_W     = 40;
  localparam int ROOT_STEPS   = 20;
  localparam int DIV_STEPS    = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 5;
  localparam int CNT_W        = 5;
  localparam int DIR_W        = 13;
  localparam int STR_W        = 13;
  localparam int DIVISOR_W    = 7;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic signed [Z_W-1:0] HALF_TURN = 24'sd737280;
  localparam int DIR_MAX      = 2880;
  localparam int STRENGTH_MAX = 4096;

  typedef enum logic {FR_HUNT, FR_COLLECT} front_state_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_SUM, BK_CORDIC_INIT, BK_CORDIC, BK_SQ_X, BK_SQ_Y,
    BK_ROOT, BK_DIV, BK_OUT
  } back_state_t;

  // round(16384*sin(d)) for d = 0..90
  localparam logic [14:0] SIN_Q14 [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
    15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
    15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
    15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
    15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // round(4096*atan(2^-i)) in degrees
  localparam logic [17:0] ATAN_TAB [0:15] = '{
    18'd184320, 18'd108810, 18'd57492, 18'd29184, 18'd14649, 18'd7331,
    18'd3667, 18'd1833, 18'd917, 18'd458, 18'd229, 18'd115, 18'd57, 18'd29,
    18'd14, 18'd7
  };

  // sine in Q1.14 of an integer angle 0..449 degrees
  function automatic logic signed [15:0] sin_deg(input logic [8:0] d);
    logic [8:0] dm;
    logic [8:0] k;
    logic       neg;
    begin
      dm  = (d >= 9'd360) ? d - 9'd360 : d;
      neg = 1'b0;
      if (dm <= 9'd90) begin
        k = dm;
      end else if (dm <= 9'd180) begin
        k = 9'd180 - dm;
      end else if (dm <= 9'd270) begin
        k = dm - 9'd180; neg = 1'b1;
      end else begin
        k = 9'd360 - dm; neg = 1'b1;
      end
      sin_deg = neg ? -$signed({1'b0, SIN_Q14[k[6:0]]}) : $signed({1'b0, SIN_Q14[k[6:0]]});
    end
  endfunction

endpackage

// File: rtl/line_sensor_ring_direction.sv
// top level of the line sensor ring direction block
// Takes serial bytes one per beat, hunts for the start code 0x1F and gathers
// FRAME_BYTES data bytes of five sensor bits each. A finished frame goes into
// a two-entry queue, so byte intake continues while the vector unit works.
// The vector unit masks the flags, sums the inner sensor unit vectors one
// sensor per cycle, runs a 16-step cordic for the angle, squares and takes a
// 20-step integer root, then a 20-step divide for the mean length, but a
// frame with no active sensor or a zero sum skips to the output. Bytes are
// taken every cycle unless both queue entries are full. A result stays on
// the output until taken while the next frame is already being worked on.
module line_sensor_ring_direction import lsrd_pkg::*; #(
  parameter int INNER_SENSORS = INNER_SENSORS_DEF,
  parameter int FRAME_BYTES   = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // rx_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [63:0]            m_tdata,   // direction, strength, active_count, sensor_flags
  output logic                   m_tuser,   // line_seen
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [NUM_SENSORS-1:0] cfg_data   // disabled_sensor_mask
);

  logic [NUM_SENSORS-1:0] mask;
  logic                   push_valid, push_ready;
  logic [NUM_SENSORS-1:0] push_flags;
  logic                   q_valid, q_pop;
  logic [NUM_SENSORS-1:0] q_flags;

  // mask register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) mask <= MASK_RESET;
    else if (cfg_valid && cfg_ready) mask <= cfg_data;
  end

  lsrd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk, .rst,
    .byte_valid(s_tvalid), .byte_ready(s_tready), .byte_data(s_tdata),
    .push_valid, .push_ready, .push_flags
  );

  lsrd_queue u_queue (
    .clk, .rst,
    .push_valid, .push_ready, .push_flags,
    .pop_valid(q_valid), .pop(q_pop), .pop_flags(q_flags)
  );

  lsrd_back #(.INNER_SENSORS(INNER_SENSORS)) u_back (
    .clk, .rst,
    .q_valid, .q_pop, .q_flags, .mask,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

endmodule

// File: rtl/lsrd_front.sv
// frame hunter: finds the start code and gathers the sensor bits of one frame
module lsrd_front import lsrd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  logic [BYTE_W-1:0]      byte_data,
  output logic                   push_valid,
  input  logic                   push_ready,
  output logic [NUM_SENSORS-1:0] push_flags
);

  front_state_t           state, state_next;
  logic [2:0]             pos, pos_next;
  logic [NUM_SENSORS-1:0] gathered, gathered_next;
  logic [NUM_SENSORS-1:0] new_bits;
  logic                   accept;
  logic                   last_byte;

  assign byte_ready = push_ready;
  assign accept     = byte_valid && byte_ready;
  assign last_byte  = (pos == 3'(FRAME_BYTES - 1));

  // spread the five data bits to their sensor slots, msb first
  always_comb begin
    new_bits = '0;
    for (int p = 0; p < FRAME_BYTES; p++) begin
      for (int j = 0; j < BITS_PER_BYTE; j++) begin
        if (pos == 3'(p)) new_bits[p*BITS_PER_BYTE + j] = byte_data[BITS_PER_BYTE-1-j];
      end
    end
  end

  assign push_flags = gathered | new_bits;
  assign push_valid = accept && (state == FR_COLLECT) && last_byte;

  // hunt and collect sequencing
  always_comb begin
    state_next    = state;
    pos_next      = pos;
    gathered_next = gathered;
    if (accept) begin
      unique case (state)
        FR_HUNT: begin
          if (byte_data == START_CODE) begin
            state_next    = FR_COLLECT;
            pos_next      = '0;
            gathered_next = '0;
          end
        end
        FR_COLLECT: begin
          gathered_next = push_flags;
          if (last_byte) begin
            state_next = FR_HUNT;
            pos_next   = '0;
          end else begin
            pos_next = pos + 3'd1;
          end
        end
        default: state_next = FR_HUNT;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FR_HUNT;
      pos      <= '0;
      gathered <= '0;
    end else begin
      state    <= state_next;
      pos      <= pos_next;
      gathered <= gathered_next;
    end
  end

endmodule

// File: rtl/lsrd_queue.sv
// two-entry frame queue between the hunter and the vector unit
module lsrd_queue import lsrd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  logic [NUM_SENSORS-1:0] push_flags,
  output logic                   pop_valid,
  input  logic                   pop,
  output logic [NUM_SENSORS-1:0] pop_flags
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [NUM_SENSORS-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr, rd_ptr;
  logic [PTR_W:0]         count;
  logic                   do_push, do_pop;

  assign push_ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_flags  = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_flags;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

// File: rtl/lsrd_back.sv
// vector unit: sensor sum, cordic angle, root of the squared length, divide
module lsrd_back import lsrd_pkg::*; #(
  parameter int INNER_SENSORS = INNER_SENSORS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic [NUM_SENSORS-1:0]  q_flags,
  input  logic [NUM_SENSORS-1:0]  mask,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [63:0]             m_tdata,  // direction, strength, active_count, sensor_flags
  output logic                    m_tuser   // line_seen
);

`include "line_sensor_ring_direction_defines.svh"

  localparam int DEG_STEP = 360 / INNER_SENSORS;
  localparam int DEG_REM  = 360 % INNER_SENSORS;

  back_state_t             state, state_next;
  logic [NUM_SENSORS-1:0]  flags;
  logic [4:0]              idx;
  logic [8:0]              deg;
  logic [5:0]              rem;
  logic signed [SUM_W-1:0] sx, sy;
  logic [CNT_W-1:0]        count;
  logic signed [XY_W-1:0]  x, y;
  logic signed [Z_W-1:0]   z;
  logic [STEP_W-1:0]       step;
  logic [SQ_W-1:0]         v, r, rbit;
  logic [DIVISOR_W:0]      drem;
  logic [ROOT_STEPS-1:0]   quo;
  logic signed [DIR_W-1:0] dir;
  logic [STR_W-1:0]        strength;

  // output registers
  logic                    out_line;
  logic signed [DIR_W-1:0] out_dir;
  logic [STR_W-1:0]        out_strength;
  logic [CNT_W-1:0]        out_count;
  logic [NUM_SENSORS-1:0]  out_flags;

  // datapath helpers
  logic signed [15:0]      cos_v, sin_v;
  logic signed [XY_W-1:0]  dx, dy;
  logic signed [Z_W-1:0]   atan_v;
  logic signed [Z_W:0]     zt;
  logic signed [Z_W:0]     zsh;
  logic [SQ_W-1:0]         trial;
  logic [DIVISOR_W:0]      dshift;
  logic [DIVISOR_W-1:0]    divisor;
  logic                    out_free;

  assign cos_v   = sin_deg(deg + 9'd90);
  assign sin_v   = sin_deg(deg);
  assign dx      = y >>> step[3:0];
  assign dy      = x >>> step[3:0];
  assign atan_v  = $signed({{(Z_W-18){1'b0}}, ATAN_TAB[step[3:0]]});
  assign zt      = -$signed({z[Z_W-1], z}) + (Z_W+1)'(128);
  assign zsh     = zt >>> 8;
  assign trial   = r + rbit;
  assign divisor = {count, 2'b00};
  assign dshift  = {drem[DIVISOR_W-1:0], quo[ROOT_STEPS-1]};
  assign out_free = !m_tvalid || m_tready;
  assign q_pop   = (state == BK_IDLE) && q_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:        if (q_valid) state_next = BK_SUM;
      BK_SUM: begin
        if (idx == 5'(INNER_SENSORS - 1)) state_next = BK_CORDIC_INIT;
      end
      BK_CORDIC_INIT: begin
        if (count == '0 || (sx == '0 && sy == '0)) state_next = BK_OUT;
        else state_next = BK_CORDIC;
      end
      BK_CORDIC:      if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = BK_SQ_X;
      BK_SQ_X:        state_next = BK_SQ_Y;
      BK_SQ_Y:        state_next = BK_ROOT;
      BK_ROOT:        if (rbit[0]) state_next = BK_DIV;
      BK_DIV:         if (step == STEP_W'(DIV_STEPS - 1)) state_next = BK_OUT;
      BK_OUT: begin
        if (out_free && step != STEP_W'(DIV_STEPS)) state_next = BK_IDLE;
      end
      default:        state_next = BK_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        flags <= q_flags & ~mask;
        idx   <= '0;
        deg   <= '0;
        rem   <= '0;
        sx    <= '0;
        sy    <= '0;
        count <= '0;
      end
      BK_SUM: begin
        if (flags[idx]) begin
          sx    <= sx + SUM_W'(cos_v);
          sy    <= sy + SUM_W'(sin_v);
          count <= count + CNT_W'(1);
        end
        idx <= idx + 5'd1;
        if (rem + 6'(DEG_REM) >= 6'(INNER_SENSORS)) begin
          rem <= rem + 6'(DEG_REM) - 6'(INNER_SENSORS);
          deg <= deg + 9'(DEG_STEP) + 9'd1;
        end else begin
          rem <= rem + 6'(DEG_REM);
          deg <= deg + 9'(DEG_STEP);
        end
      end
      BK_CORDIC_INIT: begin
        dir      <= '0;
        strength <= '0;
        step     <= '0;
        if (sx < 0) begin
          x <= -(XY_W'(sx) <<< 8);
          y <= -(XY_W'(sy) <<< 8);
          z <= (sy >= 0) ? HALF_TURN : -HALF_TURN;
        end else begin
          x <= XY_W'(sx) <<< 8;
          y <= XY_W'(sy) <<< 8;
          z <= '0;
        end
      end
      BK_CORDIC: begin
        if (y > 0) begin
          x <= x + dx; y <= y - dy; z <= z + atan_v;
        end else begin
          x <= x - dx; y <= y + dy; z <= z - atan_v;
        end
        step <= step + STEP_W'(1);
      end
      BK_SQ_X: begin
        if (zsh > (Z_W+1)'(DIR_MAX))       dir <= DIR_W'(DIR_MAX);
        else if (zsh < -(Z_W+1)'(DIR_MAX)) dir <= -DIR_W'(DIR_MAX);
        else                               dir <= zsh[DIR_W-1:0];
        v <= SQ_W'(sx) * SQ_W'(sx);
      end
      BK_SQ_Y: begin
        v    <= v + SQ_W'(SQ_W'(sy) * SQ_W'(sy));
        r    <= '0;
        rbit <= SQ_W'(1) << (2*ROOT_STEPS - 2);
      end
      BK_ROOT: begin
        if (v >= trial) begin
          v <= v - trial;
          r <= (r >> 1) + rbit;
        end else begin
          r <= r >> 1;
        end
        rbit <= rbit >> 2;
        step <= '0;
        drem <= '0;
        if (rbit[0]) begin
          // last root step, seed the divider with the final root
          quo <= (v >= trial) ? ROOT_STEPS'((r >> 1) + rbit) : ROOT_STEPS'(r >> 1);
        end
      end
      BK_DIV: begin
        if (dshift >= {1'b0, divisor}) begin
          drem <= dshift - {1'b0, divisor};
          quo  <= {quo[ROOT_STEPS-2:0], 1'b1};
        end else begin
          drem <= dshift;
          quo  <= {quo[ROOT_STEPS-2:0], 1'b0};
        end
        step <= step + STEP_W'(1);
      end
      BK_OUT: begin
        if (state == BK_OUT && step == STEP_W'(DIV_STEPS)) begin
          strength <= (quo > ROOT_STEPS'(STRENGTH_MAX)) ? STR_W'(STRENGTH_MAX)
                                                        : quo[STR_W-1:0];
          step     <= '0;
        end
      end
      default: ;
    endcase
  end

  // result register, holds until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == BK_OUT && out_free && step != STEP_W'(DIV_STEPS)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_OUT && out_free && step != STEP_W'(DIV_STEPS)) begin
      out_line     <= (count != '0);
      out_dir      <= dir;
      out_strength <= strength;
      out_count    <= count;
      out_flags    <= flags;
    end
  end

  assign m_tuser = out_line;
  assign m_tdata = {3'b000, out_flags, out_count, out_strength, out_dir};

  `LSRD_ASSERT_IMP(a_div_nonzero, state == BK_DIV, count != '0, "divide with no active sensor")
  `LSRD_ASSERT_NXT(a_pop_starts_sum, q_pop, state == BK_SUM, "popped frame not summed")
  `LSRD_ASSERT_IMP(a_no_line_zero, m_tvalid && !m_tuser,
    out_dir == '0 && out_strength == '0 && out_count == '0, "empty frame with nonzero result")

endmodule
